/* rtl/mg_pkg.sv */
package mg_pkg;

  localparam int unsigned ROUNDS = 32;
  localparam int unsigned KEY_WORDS = 8;
  localparam int unsigned ROT = 11;
  localparam int unsigned WORD_W = 32;
  localparam int unsigned INDEX_W = $clog2(KEY_WORDS);
  localparam int unsigned FIRST_REVERSED = 24;

  typedef logic [WORD_W-1:0] word_t;

  typedef struct packed {
    logic  command;
    word_t block_high;
    word_t block_low;
  } req_t;

  typedef struct packed {
    word_t result_high;
    word_t result_low;
  } res_t;

  // One pipeline stage: the Feistel halves after a round, with the command.
  typedef struct packed {
    logic  valid;
    logic  command;
    word_t a1;
    word_t a0;
  } stage_t;

  localparam logic CMD_ENCRYPT = 1'b0;
  localparam logic CMD_DECRYPT = 1'b1;

  localparam word_t KEY_RESET [KEY_WORDS] = '{
    32'hFFEEDDCC, 32'hBBAA9988, 32'h77665544, 32'h33221100,
    32'hF0F1F2F3, 32'hF4F5F6F7, 32'hF8F9FAFB, 32'hFCFDFEFF
  };

  localparam logic [3:0] SBOX [8][16] = '{
    '{4'd12, 4'd4, 4'd6, 4'd2, 4'd10, 4'd5, 4'd11, 4'd9,
      4'd14, 4'd8, 4'd13, 4'd7, 4'd0, 4'd3, 4'd15, 4'd1},
    '{4'd6, 4'd8, 4'd2, 4'd3, 4'd9, 4'd10, 4'd5, 4'd12,
      4'd1, 4'd14, 4'd4, 4'd7, 4'd11, 4'd13, 4'd0, 4'd15},
    '{4'd11, 4'd3, 4'd5, 4'd8, 4'd2, 4'd15, 4'd10, 4'd13,
      4'd14, 4'd1, 4'd7, 4'd4, 4'd12, 4'd9, 4'd6, 4'd0},
    '{4'd12, 4'd8, 4'd2, 4'd1, 4'd13, 4'd4, 4'd15, 4'd6,
      4'd7, 4'd0, 4'd10, 4'd5, 4'd3, 4'd14, 4'd9, 4'd11},
    '{4'd7, 4'd15, 4'd5, 4'd10, 4'd8, 4'd1, 4'd6, 4'd13,
      4'd0, 4'd9, 4'd3, 4'd14, 4'd11, 4'd4, 4'd2, 4'd12},
    '{4'd5, 4'd13, 4'd15, 4'd6, 4'd9, 4'd2, 4'd12, 4'd10,
      4'd11, 4'd7, 4'd8, 4'd1, 4'd4, 4'd3, 4'd14, 4'd0},
    '{4'd8, 4'd14, 4'd2, 4'd5, 4'd6, 4'd9, 4'd1, 4'd12,
      4'd15, 4'd4, 4'd11, 4'd0, 4'd13, 4'd10, 4'd3, 4'd7},
    '{4'd1, 4'd7, 4'd14, 4'd13, 4'd0, 4'd5, 4'd8, 4'd3,
      4'd4, 4'd15, 4'd10, 4'd6, 4'd9, 4'd12, 4'd11, 4'd2}
  };

  // Nibble 0 is the least significant and uses the first S-box.
  function automatic word_t subst(input word_t x);
    word_t r;
    r = '0;
    for (int i = 0; i < 8; i++) begin
      r[4*i +: 4] = SBOX[i][x[4*i +: 4]];
    end
    return r;
  endfunction

  // Key word used by a round: 0..7 three times, then 7..0; decryption
  // walks the same schedule backwards.
  function automatic logic [INDEX_W-1:0] key_index(input int unsigned round,
                                                  input logic command);
    int unsigned r;
    logic [INDEX_W-1:0] low;
    r = (command == CMD_DECRYPT) ? (ROUNDS - 1 - round) : round;
    low = r[INDEX_W-1:0];
    return (r < FIRST_REVERSED) ? low : ~low;
  endfunction

endpackage

/* rtl/mg_stream_if.sv */
interface mg_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

/* rtl/mg_round.sv */
module mg_round (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  mg_pkg::stage_t  prev,
  input  mg_pkg::word_t   rkey,
  output mg_pkg::stage_t  next
);

  logic          valid;
  logic          command;
  mg_pkg::word_t a1;
  mg_pkg::word_t a0;
  mg_pkg::word_t sum;
  mg_pkg::word_t sub;
  mg_pkg::word_t rot;

  always_comb begin
    sum = prev.a0 + rkey;
    sub = mg_pkg::subst(sum);
    rot = {sub[mg_pkg::WORD_W-mg_pkg::ROT-1:0],
           sub[mg_pkg::WORD_W-1:mg_pkg::WORD_W-mg_pkg::ROT]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= prev.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      command <= prev.command;
      a1      <= prev.a0;
      a0      <= rot ^ prev.a1;
    end
  end

  assign next = '{valid: valid, command: command, a1: a1, a0: a0};

endmodule

/* rtl/mg_outbuf.sv */
module mg_outbuf (
  input  logic           clk,
  input  logic           rst,
  input  mg_pkg::stage_t last,
  output logic           en,
  output logic           skid_full,
  mg_stream_if.source    response
);

  logic          out_valid;
  mg_pkg::res_t  out_data;
  logic          skid_valid;
  mg_pkg::res_t  skid_data;
  mg_pkg::res_t  last_res;

  // The output block is the halves swapped after the last round.
  assign last_res = '{result_high: last.a0, result_low: last.a1};

  // The pipeline moves only while the skid register is empty.
  assign en = !skid_valid;
  assign skid_full = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (response.ready) begin
        skid_valid <= 1'b0;
      end
    end else begin
      if (!out_valid || response.ready) begin
        out_valid <= last.valid;
      end else if (last.valid) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (response.ready) begin
        out_data <= skid_data;
      end
    end else begin
      if (!out_valid || response.ready) begin
        out_data <= last_res;
      end else begin
        skid_data <= last_res;
      end
    end
  end

  assign response.valid   = out_valid;
  assign response.payload = out_data;

endmodule

/* rtl/magma_block_cipher.sv */
// Magma (GOST R 34.12-2015) 64-bit block cipher, fully unrolled.
// The request channel carries a command (0 encrypt, 1 decrypt) and the two
// halves of a block; the response channel returns the processed block.
// A block transfers on request when valid and ready are both high.
// The 256-bit key is written as eight 32-bit words through wr_en, wr_index
// and wr_data; write it only while no block is in flight.
// Each of the 32 rounds is one register stage, and an output register sits
// behind the last one, so a result is on offer from that register once its
// block has passed every round. One block is taken and one delivered every
// cycle while the receiver keeps response.ready high.
// When the receiver stalls, one more block is caught in a skid register;
// then request.ready drops and the whole round pipeline holds its contents
// until the response is taken, so nothing is lost or repeated.
// Reset clears all valid bits and loads the standard test key; the block is
// ready on the first cycle after reset.
module magma_block_cipher (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         wr_en,
  input  logic [mg_pkg::INDEX_W-1:0]   wr_index,
  input  mg_pkg::word_t                wr_data,
  mg_stream_if.sink                    request,
  mg_stream_if.source                  response
);

  mg_pkg::word_t  key_word [mg_pkg::KEY_WORDS];
  mg_pkg::stage_t stage [mg_pkg::ROUNDS+1];
  mg_pkg::word_t  rkey [mg_pkg::ROUNDS];
  logic           en;
  logic           skid_full;
  logic [mg_pkg::ROUNDS:0] stage_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < mg_pkg::KEY_WORDS; i++) begin
        key_word[i] <= mg_pkg::KEY_RESET[i];
      end
    end else if (wr_en) begin
      key_word[wr_index] <= wr_data;
    end
  end

  assign request.ready = en;

  assign stage[0] = '{valid: request.valid,
                      command: request.payload.command,
                      a1: request.payload.block_high,
                      a0: request.payload.block_low};

  for (genvar i = 0; i < mg_pkg::ROUNDS; i++) begin : g_round
    assign rkey[i] = key_word[mg_pkg::key_index(i, stage[i].command)];

    mg_round u_round (
      .clk  (clk),
      .rst  (rst),
      .en   (en),
      .prev (stage[i]),
      .rkey (rkey[i]),
      .next (stage[i+1])
    );
  end

  for (genvar i = 0; i <= mg_pkg::ROUNDS; i++) begin : g_valid
    assign stage_valid[i] = stage[i].valid;
  end

  mg_outbuf u_outbuf (
    .clk       (clk),
    .rst       (rst),
    .last      (stage[mg_pkg::ROUNDS]),
    .en        (en),
    .skid_full (skid_full),
    .response  (response)
  );

`ifndef SYNTHESIS
  // A caught block always sits behind a result that is on offer.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_full |-> response.valid)
    else $error("skid register full without a pending response");

  // The skid register fills only when the receiver refused a result.
  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_full) |-> $past(response.valid && !response.ready))
    else $error("skid register filled without a stall");

  // While the pipeline is held, the round stages keep their valid bits.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!en && !$past(rst)) |=> $stable(stage_valid[mg_pkg::ROUNDS:1]))
    else $error("round pipeline moved while stalled");
`endif

endmodule

/* test/magma_checker.sv */
`timescale 1ns / 100ps

module magma_checker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       wr_en,
  input  logic [mg_pkg::INDEX_W-1:0] wr_index,
  input  mg_pkg::word_t              wr_data,
  input  logic                       req_valid,
  input  logic                       req_ready,
  input  mg_pkg::req_t               req_payload,
  input  logic                       rsp_valid,
  input  logic                       rsp_ready,
  input  mg_pkg::res_t               rsp_payload,
  output int unsigned                pending,
  output int unsigned                fail_count
);
  import mg_pkg::*;

  localparam word_t KEY_INIT [8] = '{
    32'hFFEEDDCC, 32'hBBAA9988, 32'h77665544, 32'h33221100,
    32'hF0F1F2F3, 32'hF4F5F6F7, 32'hF8F9FAFB, 32'hFCFDFEFF
  };

  localparam logic [3:0] NIBBLE_MAP [8][16] = '{
    '{12, 4, 6, 2, 10, 5, 11, 9, 14, 8, 13, 7, 0, 3, 15, 1},
    '{6, 8, 2, 3, 9, 10, 5, 12, 1, 14, 4, 7, 11, 13, 0, 15},
    '{11, 3, 5, 8, 2, 15, 10, 13, 14, 1, 7, 4, 12, 9, 6, 0},
    '{12, 8, 2, 1, 13, 4, 15, 6, 7, 0, 10, 5, 3, 14, 9, 11},
    '{7, 15, 5, 10, 8, 1, 6, 13, 0, 9, 3, 14, 11, 4, 2, 12},
    '{5, 13, 15, 6, 9, 2, 12, 10, 11, 7, 8, 1, 4, 3, 14, 0},
    '{8, 14, 2, 5, 6, 9, 1, 12, 15, 4, 11, 0, 13, 10, 3, 7},
    '{1, 7, 14, 13, 0, 5, 8, 3, 4, 15, 10, 6, 9, 12, 11, 2}
  };

  word_t key_reg [8];
  res_t  cipher_q [$];
  res_t  oldest;

  function automatic res_t cipher_block(input logic cmd, input word_t hi, input word_t lo);
    word_t left, right, sum, sub, mixed;
    int unsigned step, k;
    left = hi;
    right = lo;
    for (int r = 0; r < 32; r++) begin
      step = (cmd == CMD_DECRYPT) ? 31 - r : r;
      // Key words run forward for three passes, then backward for the last.
      k = (step < 24) ? step % 8 : 7 - step % 8;
      sum = right + key_reg[k];
      for (int n = 0; n < 8; n++) begin
        sub[4*n +: 4] = NIBBLE_MAP[n][sum[4*n +: 4]];
      end
      mixed = {sub[20:0], sub[31:21]} ^ left;
      left = right;
      right = mixed;
    end
    // The halves come out swapped after the last round.
    return '{result_high: right, result_low: left};
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    fail_count++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 8; i++) begin
        key_reg[i] = KEY_INIT[i];
      end
      cipher_q.delete();
      fail_count = 0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (cipher_q.size() == 0) begin
          report_mismatch($sformatf("result %08h_%08h with none outstanding",
                                    rsp_payload.result_high, rsp_payload.result_low));
        end else begin
          oldest = cipher_q.pop_front();
          if (rsp_payload.result_high !== oldest.result_high) begin
            report_mismatch($sformatf("result_high %08h, expected %08h",
                                      rsp_payload.result_high, oldest.result_high));
          end
          if (rsp_payload.result_low !== oldest.result_low) begin
            report_mismatch($sformatf("result_low %08h, expected %08h",
                                      rsp_payload.result_low, oldest.result_low));
          end
        end
      end
      if (req_valid && req_ready) begin
        cipher_q.push_back(cipher_block(req_payload.command, req_payload.block_high,
                                        req_payload.block_low));
      end
      if (wr_en) begin
        key_reg[wr_index] = wr_data;
      end
    end
    pending = cipher_q.size();
  end

endmodule

/* test/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
  import mg_pkg::*;

  localparam int unsigned LIMIT_CYCLES = 200000;
  localparam int unsigned HOLD_CYCLES = 150;
  localparam int unsigned BLOCKS_PER_PHASE = 75;
  localparam int unsigned KEY_PHASES = 8;
  localparam int unsigned SETTLE_CYCLES = 40;

  logic               clk;
  logic               rst;
  logic               wr_en;
  logic [INDEX_W-1:0] wr_index;
  word_t              wr_data;
  int unsigned        pending;
  int unsigned        fail_count;
  int unsigned        cycle_count;
  int unsigned        send_idle_pct;
  int unsigned        stall_pct;
  int unsigned        hold_asks;

  mg_stream_if #(.payload_t(req_t)) request_ch ();
  mg_stream_if #(.payload_t(res_t)) response_ch ();

  magma_block_cipher DUT (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .request  (request_ch),
    .response (response_ch)
  );

  magma_checker cipher_check (
    .clk         (clk),
    .rst         (rst),
    .wr_en       (wr_en),
    .wr_index    (wr_index),
    .wr_data     (wr_data),
    .req_valid   (request_ch.valid),
    .req_ready   (request_ch.ready),
    .req_payload (request_ch.payload),
    .rsp_valid   (response_ch.valid),
    .rsp_ready   (response_ch.ready),
    .rsp_payload (response_ch.payload),
    .pending     (pending),
    .fail_count  (fail_count)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  function automatic word_t pick_word();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      2: return word_t'(1) << $urandom_range(31);
      3: return ~(word_t'(1) << $urandom_range(31));
      default: return $urandom;
    endcase
  endfunction

  // Offers one block, with random idle cycles first, and returns at the
  // falling edge after its transfer with valid still high.
  task automatic send_block(input logic cmd, input word_t hi, input word_t lo);
    while ($urandom_range(99) < send_idle_pct) begin
      request_ch.valid <= 1'b0;
      @(negedge clk);
    end
    request_ch.valid <= 1'b1;
    request_ch.payload <= '{command: cmd, block_high: hi, block_low: lo};
    @(posedge clk);
    while (!request_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    request_ch.valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  task automatic load_key(input word_t words [8]);
    for (int i = 0; i < 8; i++) begin
      wr_en <= 1'b1;
      wr_index <= INDEX_W'(i);
      wr_data <= words[i];
      @(negedge clk);
    end
    wr_en <= 1'b0;
  endtask

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    int unsigned holds_done;
    holds_done = 0;
    response_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_asks != holds_done) begin
        holds_done++;
        response_ch.ready <= 1'b0;
        for (int n = 0; n < HOLD_CYCLES; n++) @(negedge clk);
      end
      response_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("simulation failed");
    $finish;
  end

  initial begin
    word_t key_words [8];
    logic  cmd;
    rst = 1'b1;
    wr_en = 1'b0;
    wr_index = '0;
    wr_data = '0;
    request_ch.valid = 1'b0;
    request_ch.payload = '0;
    send_idle_pct = 0;
    stall_pct = 0;
    hold_asks = 0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    // Standard test vector under the reset key, both ways.
    send_block(CMD_ENCRYPT, 32'hFEDCBA98, 32'h76543210);
    send_block(CMD_DECRYPT, 32'h4EE901E5, 32'hC2D8CA3D);
    for (int c = 0; c < 2; c++) begin
      cmd = (c == 0) ? CMD_ENCRYPT : CMD_DECRYPT;
      send_block(cmd, 32'h00000000, 32'h00000000);
      send_block(cmd, 32'hFFFFFFFF, 32'hFFFFFFFF);
      send_block(cmd, 32'h00000000, 32'hFFFFFFFF);
      send_block(cmd, 32'hFFFFFFFF, 32'h00000000);
      send_block(cmd, 32'h80000000, 32'h00000001);
      send_block(cmd, 32'h00000001, 32'h80000000);
    end

    for (int ph = 0; ph < KEY_PHASES; ph++) begin
      wait_drained();
      for (int i = 0; i < 8; i++) begin
        if (ph == 0) begin
          key_words[i] = '0;
        end else if (ph == 1) begin
          key_words[i] = '1;
        end else begin
          key_words[i] = pick_word();
        end
      end
      load_key(key_words);
      case (ph % 4)
        0: begin
          send_idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          send_idle_pct = 61;
          stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct = 61;
        end
        default: begin
          send_idle_pct = 30;
          stall_pct = 30;
        end
      endcase
      for (int n = 0; n < BLOCKS_PER_PHASE; n++) begin
        // With the sender never idle, a long hold-off fills the pipeline.
        if (ph == 4 && n == 10) hold_asks++;
        if (ph == 5 && n == 30) wait_drained();
        cmd = $urandom_range(1) ? CMD_DECRYPT : CMD_ENCRYPT;
        send_block(cmd, pick_word(), pick_word());
      end
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
